/* sv/csg_pkg.sv */
// ----------------------------------------------------------------------------
// csg_pkg
// shared widths, opcodes and register indexes of the cubic spline grid painter
// ----------------------------------------------------------------------------
package csg_pkg;

    localparam int GRID_BITS_DEF = 6;
    localparam int POS_W         = 32;
    localparam int CIDX_W        = 6;
    localparam int ACC_W         = 40;
    localparam int OUT_W         = 48;
    localparam int CFG_W         = 32;
    localparam int MUL_W         = 34;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int W_W           = 17;

    // floor(x / 6) = (x * DIV6_K) >> DIV6_SH for x below 2^20
    localparam int DIV6_SH       = 22;
    localparam logic [19:0] DIV6_K = 20'((2 ** DIV6_SH + 5) / 6);

    localparam logic [1:0] OP_PAINT = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] REG_CELLS_PER_LENGTH = 2'd0;
    localparam logic [1:0] REG_OFFSET_HALF      = 2'd1;
    localparam logic [1:0] REG_NORM_SCALE       = 2'd2;

endpackage

/* sv/csg_if.sv */
// ----------------------------------------------------------------------------
// csg_req_if / csg_rsp_if
// valid/ready channels carrying request and response beats
// ----------------------------------------------------------------------------
interface csg_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        opcode;
    logic signed [csg_pkg::POS_W-1:0]  pos_x;
    logic signed [csg_pkg::POS_W-1:0]  pos_y;
    logic signed [csg_pkg::POS_W-1:0]  pos_z;
    logic [csg_pkg::CIDX_W-1:0]        cell_i;
    logic [csg_pkg::CIDX_W-1:0]        cell_j;
    logic [csg_pkg::CIDX_W-1:0]        cell_k;

    modport source (output valid, opcode, pos_x, pos_y, pos_z, cell_i, cell_j, cell_k,
                    input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, pos_z, cell_i, cell_j, cell_k,
                    output ready);
endinterface

interface csg_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [csg_pkg::OUT_W-1:0]   density;

    modport source (output valid, density, input ready);
    modport sink   (input valid, density, output ready);
endinterface

/* sv/csg_ram.sv */
// ----------------------------------------------------------------------------
// csg_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module csg_ram #(
    parameter int WIDTH      = 40,
    parameter int DEPTH_BITS = 18
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic                  we,
    input  logic [DEPTH_BITS-1:0] addr,
    input  logic [WIDTH-1:0]      wdata,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [2 ** DEPTH_BITS];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/csg_mul.sv */
// ----------------------------------------------------------------------------
// csg_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module csg_mul (
    input  logic                                clk,
    input  logic signed [csg_pkg::MUL_W-1:0]    a,
    input  logic signed [csg_pkg::MUL_W-1:0]    b,
    output logic signed [csg_pkg::PROD_W-1:0]   prod
);
    import csg_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

/* sv/cubic_spline_grid_painter.sv */
// ----------------------------------------------------------------------------
// cubic_spline_grid_painter
// paints particles onto a periodic cubic grid with cubic spline weights
// ----------------------------------------------------------------------------
// Usage: requests enter on req (valid/ready), one beat per operation; read
// results leave on rsp; the user must see that registers are written on
// cfg_wr_en/cfg_index/cfg_data only while the block is idle, which the block
// itself does not enforce. req.ready is high only when the sequencer is idle.
// Paint: weight setup (3 axes x 8 products, issue and capture on the one
// shared multiplier), then update of 64 cells (grid ram read, two multiplies
// and a saturating write per cell).
// Read: ram read, two partial products of cell times scale, then the
// density beat. Clear: one cell write per cycle over the whole grid.
// Reset: registers take their defaults; the grid holds no defined value until
// a clear has run. If rsp stalls, the result waits in the output register,
// further items are still accepted, and a second read waits for it to drain.
// ----------------------------------------------------------------------------
module cubic_spline_grid_painter #(
    parameter int GRID_BITS = csg_pkg::GRID_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    csg_req_if.sink                     req,
    csg_rsp_if.source                   rsp,
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_index,
    input  logic [csg_pkg::CFG_W-1:0]   cfg_data
);
    import csg_pkg::*;

    localparam int ADDR_W = 3 * GRID_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_AXIS, S_UPD0, S_UPD1, S_UPD2,
        S_RD0, S_RD1, S_RD2, S_RD3, S_CLEAR
    } state_t;

    state_t                  state_reg;
    logic [31:0]             cpl_reg;
    logic                    offset_half_reg;
    logic [31:0]             norm_reg;

    logic signed [POS_W-1:0] pos_reg [3];
    logic [1:0]              ax_reg;
    logic [2:0]              st_reg;
    logic                    phase_reg;
    logic [15:0]             d_reg;
    logic [31:0]             d2_reg;
    logic [47:0]             d3_reg;
    logic [32:0]             e2_reg;
    logic [48:0]             e3_reg;
    logic [W_W-1:0]          w0_reg;
    logic [W_W-1:0]          w1_reg;
    logic [W_W-1:0]          wx_reg [4];
    logic [W_W-1:0]          wy_reg [4];
    logic [W_W-1:0]          wz_reg [4];
    logic [GRID_BITS-1:0]    cx_reg;
    logic [GRID_BITS-1:0]    cy_reg;
    logic [GRID_BITS-1:0]    cz_reg;
    logic [5:0]              cnt_reg;
    logic [ADDR_W-1:0]       rd_addr_reg;
    logic [ADDR_W-1:0]       clr_ptr_reg;
    logic [63:0]             acc_lo_reg;
    logic                    out_valid_reg;
    logic [OUT_W-1:0]        density_reg;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;

    logic                    ram_en;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_addr;
    logic [ACC_W-1:0]        ram_wdata;
    logic [ACC_W-1:0]        ram_rdata;

    logic [1:0]              p_idx;
    logic [1:0]              q_idx;
    logic [1:0]              r_idx;
    logic [ADDR_W-1:0]       upd_addr;
    logic signed [POS_W-1:0] pos_sel;
    logic [16:0]             e_val;
    logic [19:0]             x0;
    logic [19:0]             x1;
    logic [19:0]             x3;
    logic [51:0]             num1;
    logic [63:0]             u_val;
    logic [W_W-1:0]          w_new;
    logic [W_W-1:0]          w2_val;
    logic [26:0]             add_val;
    logic [ACC_W:0]          sum_val;
    logic [ACC_W-1:0]        sat_val;
    logic [71:0]             total;
    logic [55:0]             v_val;
    logic [OUT_W-1:0]        v_sat;
    logic [17:0]             wx_sum;

    csg_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    csg_ram #(
        .WIDTH      (ACC_W),
        .DEPTH_BITS (ADDR_W)
    ) u_grid (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign p_idx    = cnt_reg[5:4];
    assign q_idx    = cnt_reg[3:2];
    assign r_idx    = cnt_reg[1:0];
    assign upd_addr = {cx_reg + GRID_BITS'(p_idx) - GRID_BITS'(1),
                       cy_reg + GRID_BITS'(q_idx) - GRID_BITS'(1),
                       cz_reg + GRID_BITS'(r_idx) - GRID_BITS'(1)};
    assign pos_sel  = (ax_reg == 2'd0) ? pos_reg[0] : ((ax_reg == 2'd1) ? pos_reg[1] : pos_reg[2]);
    assign e_val    = 17'(65536) - 17'(d_reg);
    assign x0       = 20'(({1'b0, e3_reg} + (50'(3) << 32)) >> 32);
    assign num1     = 52'({d3_reg, 1'b0}) + 52'(d3_reg) + (52'(1) << 50)
                      - ((52'({d2_reg, 1'b0}) + 52'({d2_reg, 2'b0})) << 16);
    assign x1       = 20'((num1 + (52'(3) << 32)) >> 32);
    assign x3       = 20'(({2'b0, d3_reg} + (50'(3) << 32)) >> 32);
    assign u_val    = offset_half_reg ? prod[63:0] : (prod[63:0] - 64'h8000_0000);
    assign w_new    = prod[DIV6_SH +: W_W];
    assign w2_val   = W_W'(65536) - w0_reg - w1_reg - w_new;
    assign add_val  = 27'((prod[50:0] + (51'(1) << 23)) >> 24);
    assign sum_val  = {1'b0, ram_rdata} + (ACC_W + 1)'(add_val);
    assign sat_val  = sum_val[ACC_W] ? {ACC_W{1'b1}} : sum_val[ACC_W-1:0];
    assign total    = {prod[39:0], 32'd0} + 72'(acc_lo_reg);
    assign v_val    = total[71:16];
    assign v_sat    = (|v_val[55:OUT_W]) ? {OUT_W{1'b1}} : v_val[OUT_W-1:0];
    assign wx_sum   = 18'(wx_reg[0]) + 18'(wx_reg[1]) + 18'(wx_reg[2]) + 18'(wx_reg[3]);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_AXIS:
            begin
                case (st_reg)
                    3'd0:
                    begin
                        mul_a = {{2{pos_sel[POS_W-1]}}, pos_sel};
                        mul_b = {2'b00, cpl_reg};
                    end
                    3'd1:
                    begin
                        mul_a = MUL_W'(d_reg);
                        mul_b = MUL_W'(d_reg);
                    end
                    3'd2:
                    begin
                        mul_a = MUL_W'(d2_reg);
                        mul_b = MUL_W'(d_reg);
                    end
                    3'd3:
                    begin
                        mul_a = MUL_W'(e_val);
                        mul_b = MUL_W'(e_val);
                    end
                    3'd4:
                    begin
                        mul_a = MUL_W'(e2_reg);
                        mul_b = MUL_W'(e_val);
                    end
                    3'd5:
                    begin
                        mul_a = MUL_W'(x0);
                        mul_b = MUL_W'(DIV6_K);
                    end
                    3'd6:
                    begin
                        mul_a = MUL_W'(x1);
                        mul_b = MUL_W'(DIV6_K);
                    end
                    default:
                    begin
                        mul_a = MUL_W'(x3);
                        mul_b = MUL_W'(DIV6_K);
                    end
                endcase
            end
            S_UPD0:
            begin
                mul_a = MUL_W'(wx_reg[p_idx]);
                mul_b = MUL_W'(wy_reg[q_idx]);
            end
            S_UPD1, S_UPD2:
            begin
                mul_a = MUL_W'(prod[32:0]);
                mul_b = MUL_W'(wz_reg[r_idx]);
            end
            S_RD1:
            begin
                mul_a = MUL_W'(ram_rdata[31:0]);
                mul_b = MUL_W'(norm_reg);
            end
            S_RD2, S_RD3:
            begin
                mul_a = MUL_W'(ram_rdata[ACC_W-1:32]);
                mul_b = MUL_W'(norm_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // grid ram port
    always_comb
    begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = upd_addr;
        ram_wdata = sat_val;
        case (state_reg)
            S_UPD0:
            begin
                ram_en = 1'b1;
            end
            S_UPD2:
            begin
                ram_en = 1'b1;
                ram_we = 1'b1;
            end
            S_RD0:
            begin
                ram_en   = 1'b1;
                ram_addr = rd_addr_reg;
            end
            S_CLEAR:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = clr_ptr_reg;
                ram_wdata = '0;
            end
            default:
            begin
                ram_en = 1'b0;
            end
        endcase
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.density = density_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cpl_reg         <= 32'd65536;
            offset_half_reg <= 1'b0;
            norm_reg        <= 32'd65536;
            ax_reg          <= '0;
            st_reg          <= '0;
            phase_reg       <= 1'b0;
            cnt_reg         <= '0;
            clr_ptr_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (state_reg == S_RD3 && (!out_valid_reg || rsp.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_CELLS_PER_LENGTH: cpl_reg         <= cfg_data;
                    REG_OFFSET_HALF:      offset_half_reg <= cfg_data[0];
                    REG_NORM_SCALE:       norm_reg        <= cfg_data;
                    default:              ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        pos_reg[0]  <= req.pos_x;
                        pos_reg[1]  <= req.pos_y;
                        pos_reg[2]  <= req.pos_z;
                        rd_addr_reg <= {GRID_BITS'(req.cell_i), GRID_BITS'(req.cell_j),
                                        GRID_BITS'(req.cell_k)};
                        ax_reg      <= '0;
                        st_reg      <= '0;
                        phase_reg   <= 1'b0;
                        case (req.opcode)
                            OP_PAINT: state_reg <= S_AXIS;
                            OP_READ:  state_reg <= S_RD0;
                            OP_CLEAR: state_reg <= S_CLEAR;
                            default:  state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_AXIS:
                begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg)
                    begin
                        st_reg <= st_reg + 3'd1;
                        case (st_reg)
                            3'd0:
                            begin
                                d_reg <= u_val[31:16];
                                case (ax_reg)
                                    2'd0:    cx_reg <= u_val[32 +: GRID_BITS];
                                    2'd1:    cy_reg <= u_val[32 +: GRID_BITS];
                                    default: cz_reg <= u_val[32 +: GRID_BITS];
                                endcase
                            end
                            3'd1: d2_reg <= prod[31:0];
                            3'd2: d3_reg <= prod[47:0];
                            3'd3: e2_reg <= prod[32:0];
                            3'd4: e3_reg <= prod[48:0];
                            3'd5: w0_reg <= w_new;
                            3'd6: w1_reg <= w_new;
                            default:
                            begin
                                case (ax_reg)
                                    2'd0:
                                    begin
                                        wx_reg[0] <= w0_reg;
                                        wx_reg[1] <= w1_reg;
                                        wx_reg[2] <= w2_val;
                                        wx_reg[3] <= w_new;
                                    end
                                    2'd1:
                                    begin
                                        wy_reg[0] <= w0_reg;
                                        wy_reg[1] <= w1_reg;
                                        wy_reg[2] <= w2_val;
                                        wy_reg[3] <= w_new;
                                    end
                                    default:
                                    begin
                                        wz_reg[0] <= w0_reg;
                                        wz_reg[1] <= w1_reg;
                                        wz_reg[2] <= w2_val;
                                        wz_reg[3] <= w_new;
                                    end
                                endcase
                                ax_reg <= ax_reg + 2'd1;
                                if (ax_reg == 2'd2)
                                begin
                                    cnt_reg   <= '0;
                                    state_reg <= S_UPD0;
                                end
                            end
                        endcase
                    end
                end
                S_UPD0: state_reg <= S_UPD1;
                S_UPD1: state_reg <= S_UPD2;
                S_UPD2:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_UPD0;
                    end
                end
                S_RD0: state_reg <= S_RD1;
                S_RD1: state_reg <= S_RD2;
                S_RD2:
                begin
                    acc_lo_reg <= prod[63:0];
                    state_reg  <= S_RD3;
                end
                S_RD3:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        density_reg <= v_sat;
                        state_reg   <= S_IDLE;
                    end
                end
                S_CLEAR:
                begin
                    clr_ptr_reg <= clr_ptr_reg + ADDR_W'(1);
                    if (clr_ptr_reg == {ADDR_W{1'b1}})
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // spline weights of the x axis sum to one
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD0 && cnt_reg == 6'd0) |-> (wx_sum == 18'd65536))
        else $error("x weights do not sum to one");

    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cnt_reg == 6'd0 && clr_ptr_reg == '0))
        else $error("loop counters not at rest when idle");

    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RD3))
        else $error("response beat without a read");

    a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_en && ram_we) |-> (state_reg == S_UPD2 || state_reg == S_CLEAR))
        else $error("grid write outside update or clear");

endmodule
